>>> rtl/rc_pulse_width_capture_defines.svh
// Assertion macros for the RC pulse width capture block.
`ifndef RC_PULSE_WIDTH_CAPTURE_DEFINES_SVH
`define RC_PULSE_WIDTH_CAPTURE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc_pulse_width_capture: check failed");

// Next-cycle implication, disabled during reset.
`define RPWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc_pulse_width_capture: check failed");

`endif

>>> rtl/rc_pwc_pkg.sv
// Package with constants and types for the RC pulse width capture block.
package rc_pwc_pkg;

    localparam int NUM_CHANNELS = 10;
    localparam int STAMP_BITS   = 16;
    localparam int CH_W         = 4;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [CH_W:0] CH_COUNT = (CH_W + 1)'(NUM_CHANNELS);

    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [CH_W-1:0]       chan_t;
    typedef logic [CH_IDX_W-1:0]   chan_idx_t;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_RISING  = 2'd1,
        MODE_FALLING = 2'd2
    } mode_t;

    typedef enum logic {
        ACT_CAPTURE = 1'b0,
        ACT_READ    = 1'b1
    } action_t;

endpackage

>>> rtl/rc_pulse_width_capture.sv
// Two register stages: the input register (s1_*), then the output register.
// Throughput: one item per cycle unless out_stall holds a full output; per-channel state
// is updated as an item leaves the input register; the next item reads it without forwarding.
// Reset (rst_n, asynchronous, active low): pipeline empty, all channels in init mode,
// all stored stamps, periods and high times cleared to zero.
`include "rc_pulse_width_capture_defines.svh"

module rc_pulse_width_capture (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [3:0]  channel,
    input  logic [15:0] stamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] high_time,
    output logic [15:0] period,
    output logic        arm_falling,
    output logic        error
);

    logic                     s1_valid_reg;
    logic                     s1_action_reg;
    rc_pwc_pkg::chan_t        s1_channel_reg;
    rc_pwc_pkg::stamp_t       s1_stamp_reg;

    logic                     out_valid_reg;
    logic [15:0]              high_time_reg;
    logic [15:0]              period_reg;
    logic                     arm_falling_reg;
    logic                     error_reg;

    rc_pwc_pkg::mode_t        mode_reg   [rc_pwc_pkg::NUM_CHANNELS];
    rc_pwc_pkg::stamp_t       rise_reg   [rc_pwc_pkg::NUM_CHANNELS];
    rc_pwc_pkg::stamp_t       period_st_reg [rc_pwc_pkg::NUM_CHANNELS];
    rc_pwc_pkg::stamp_t       high_st_reg   [rc_pwc_pkg::NUM_CHANNELS];

    logic                     out_free;
    logic                     s1_adv;
    logic                     in_xfer;
    logic                     ch_ok;
    rc_pwc_pkg::chan_idx_t    ch_idx;
    rc_pwc_pkg::mode_t        cur_mode;
    rc_pwc_pkg::mode_t        mode_next;
    rc_pwc_pkg::stamp_t       cur_rise;
    rc_pwc_pkg::stamp_t       rise_next;
    rc_pwc_pkg::stamp_t       period_next;
    rc_pwc_pkg::stamp_t       high_next;
    rc_pwc_pkg::stamp_t       delta;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    assign ch_ok  = {1'b0, s1_channel_reg} < rc_pwc_pkg::CH_COUNT;
    assign ch_idx = s1_channel_reg[rc_pwc_pkg::CH_IDX_W-1:0];

    always_comb
    begin
        cur_mode    = rc_pwc_pkg::MODE_INIT;
        cur_rise    = '0;
        period_next = '0;
        high_next   = '0;
        if (ch_ok)
        begin
            cur_mode    = mode_reg[ch_idx];
            cur_rise    = rise_reg[ch_idx];
            period_next = period_st_reg[ch_idx];
            high_next   = high_st_reg[ch_idx];
        end
        delta     = s1_stamp_reg - cur_rise;
        mode_next = cur_mode;
        rise_next = cur_rise;
        if (s1_action_reg == rc_pwc_pkg::ACT_CAPTURE)
        begin
            case (cur_mode)
                rc_pwc_pkg::MODE_INIT:
                begin
                    rise_next = s1_stamp_reg;
                    mode_next = rc_pwc_pkg::MODE_FALLING;
                end
                rc_pwc_pkg::MODE_RISING:
                begin
                    period_next = delta;
                    rise_next   = s1_stamp_reg;
                    mode_next   = rc_pwc_pkg::MODE_FALLING;
                end
                default:
                begin
                    high_next = delta;
                    mode_next = rc_pwc_pkg::MODE_RISING;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rc_pwc_pkg::NUM_CHANNELS; i++)
            begin
                mode_reg[i]      <= rc_pwc_pkg::MODE_INIT;
                rise_reg[i]      <= '0;
                period_st_reg[i] <= '0;
                high_st_reg[i]   <= '0;
            end
        end
        else if (s1_adv && ch_ok)
        begin
            mode_reg[ch_idx]      <= mode_next;
            rise_reg[ch_idx]      <= rise_next;
            period_st_reg[ch_idx] <= period_next;
            high_st_reg[ch_idx]   <= high_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_action_reg  <= action;
            s1_channel_reg <= channel;
            s1_stamp_reg   <= stamp;
        end
        if (s1_adv)
        begin
            if (ch_ok)
            begin
                high_time_reg   <= 16'(high_next);
                period_reg      <= 16'(period_next);
                arm_falling_reg <= (mode_next != rc_pwc_pkg::MODE_INIT) &&
                                   (mode_next != rc_pwc_pkg::MODE_RISING);
                error_reg       <= 1'b0;
            end
            else
            begin
                high_time_reg   <= '0;
                period_reg      <= '0;
                arm_falling_reg <= 1'b0;
                error_reg       <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign high_time   = high_time_reg;
    assign period      = period_reg;
    assign arm_falling = arm_falling_reg;
    assign error       = error_reg;

    `RPWC_ASSERT_NOW(a_error_zero, clk, rst_n, out_valid_reg && error_reg,
        high_time_reg == 16'd0 && period_reg == 16'd0 && !arm_falling_reg)
    `RPWC_ASSERT_NOW(a_stall_only_full, clk, rst_n, in_stall,
        s1_valid_reg && out_valid_reg && out_stall)
    `RPWC_ASSERT_NEXT(a_capture_toggles, clk, rst_n,
        s1_adv && ch_ok && s1_action_reg == rc_pwc_pkg::ACT_CAPTURE,
        out_valid_reg && !error_reg &&
        arm_falling_reg == ($past(cur_mode) != rc_pwc_pkg::MODE_FALLING))
    `RPWC_ASSERT_NEXT(a_read_keeps_mode, clk, rst_n,
        s1_adv && ch_ok && s1_action_reg == rc_pwc_pkg::ACT_READ,
        arm_falling_reg == ($past(cur_mode) == rc_pwc_pkg::MODE_FALLING))

endmodule
